[sv/twc_pkg.sv]
package twc_pkg;

  localparam int THREAD_DEPTH  = 256;
  localparam int PALETTE_DEPTH = 256;
  localparam int COORD_BITS    = 16;

  localparam int THREAD_AW  = $clog2(THREAD_DEPTH);
  localparam int PAL_AW     = $clog2(PALETTE_DEPTH);
  localparam int CFG_W      = 9;
  localparam int PROD_W     = COORD_BITS + CFG_W;
  localparam int DIFF_W     = COORD_BITS + CFG_W + 1;
  localparam int REM_W      = 9;
  localparam int REM_STEP   = 4;
  localparam int DIV_BITS   = ((DIFF_W + REM_STEP - 1) / REM_STEP) * REM_STEP;
  localparam int REM_STAGES = DIV_BITS / REM_STEP;

  typedef enum logic [1:0] {
    OP_LOAD_WARP = 2'd0,
    OP_LOAD_WEFT = 2'd1,
    OP_LOAD_PAL  = 2'd2,
    OP_SAMPLE    = 2'd3
  } opcode_t;

  typedef enum logic [2:0] {
    REG_WARP_LEN    = 3'd0,
    REG_WEFT_LEN    = 3'd1,
    REG_PALETTE_LEN = 3'd2,
    REG_PERIOD_LEN  = 3'd3,
    REG_OVER_COUNT  = 3'd4,
    REG_ADVANCE     = 3'd5,
    REG_RIB         = 3'd6
  } reg_index_t;

  typedef struct packed {
    logic [1:0]                   opcode;
    logic [7:0]                   entry_index;
    logic [7:0]                   shade_value;
    logic [7:0]                   load_red;
    logic [7:0]                   load_green;
    logic [7:0]                   load_blue;
    logic [7:0]                   load_alpha;
    logic signed [COORD_BITS-1:0] end_coord;
    logic signed [COORD_BITS-1:0] pick_coord;
  } cmd_t;

  typedef struct packed {
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
    logic [7:0] pixel_alpha;
    logic       warp_over;
  } result_t;

endpackage

[sv/twc_ram.sv]
module twc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/twc_rem.sv]
// Pipelined restoring remainder, REM_STEP quotient bits per stage.
module twc_rem (
  input  logic                          clk,
  input  logic [twc_pkg::DIV_BITS-1:0]  dividend,
  input  logic [twc_pkg::REM_W-1:0]     divisor,
  output logic [twc_pkg::REM_W-1:0]     remainder
);

  logic [twc_pkg::REM_W-1:0]    rem_q [twc_pkg::REM_STAGES];
  logic [twc_pkg::DIV_BITS-1:0] sh_q  [twc_pkg::REM_STAGES];

  for (genvar s = 0; s < twc_pkg::REM_STAGES; s++) begin : g_stage
    logic [twc_pkg::REM_W-1:0]    r_in;
    logic [twc_pkg::DIV_BITS-1:0] d_in;
    logic [twc_pkg::REM_W-1:0]    r_out;
    logic [twc_pkg::DIV_BITS-1:0] d_out;

    if (s == 0) begin : g_first
      assign r_in = '0;
      assign d_in = dividend;
    end else begin : g_next
      assign r_in = rem_q[s-1];
      assign d_in = sh_q[s-1];
    end

    always_comb begin
      logic [twc_pkg::REM_W:0] t;
      r_out = r_in;
      d_out = d_in;
      for (int k = 0; k < twc_pkg::REM_STEP; k++) begin
        t = {r_out, d_out[twc_pkg::DIV_BITS-1]};
        d_out = d_out << 1;
        if (t >= {1'b0, divisor}) begin
          t = t - {1'b0, divisor};
        end
        r_out = t[twc_pkg::REM_W-1:0];
      end
    end

    always_ff @(posedge clk) begin
      rem_q[s] <= r_out;
      sh_q[s]  <= d_out;
    end
  end

  assign remainder = rem_q[twc_pkg::REM_STAGES-1];

endmodule

[sv/twill_cloth_pixel_shader.sv]
// Twill cloth pixel shader. One command transaction is taken every clock
// (busy stays low); a sample gives one result, strobed on done for a single
// cycle once it has passed the capture, product and difference stages,
// the remainder units (four bits a stage) and the fix-up, table, palette,
// rib and output stages; loads give none. Results cannot be held off by the receiver.
// Loads are written into the shade and palette RAMs at the pipeline stage
// where samples read them, so program order is kept with no forwarding.
// Configuration is taken at once on its own channel and should only be
// written while no command is in flight.
module twill_cloth_pixel_shader (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  twc_pkg::cmd_t     cmd,
  output logic              done,
  output twc_pkg::result_t  result,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [2:0]        cfg_index,
  input  logic [8:0]        cfg_data
);

  localparam int LAT = 3 + twc_pkg::REM_STAGES + 5;

  // side data riding alongside the remainder pipeline
  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  idx;
    logic [7:0]  shade;
    logic [31:0] rgba;
    logic        neg_d;
    logic        neg_e;
    logic        neg_p;
  } side_t;

  // ---- configuration registers ----
  logic [8:0]        warp_len, weft_len, palette_len, period_len, over_count;
  logic signed [8:0] advance_step;
  logic [7:0]        rib_fraction;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (rst) begin
      warp_len     <= '0;
      weft_len     <= '0;
      palette_len  <= '0;
      period_len   <= 9'd4;
      over_count   <= 9'd2;
      advance_step <= 9'sd1;
      rib_fraction <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        twc_pkg::REG_WARP_LEN:    warp_len     <= cfg_data;
        twc_pkg::REG_WEFT_LEN:    weft_len     <= cfg_data;
        twc_pkg::REG_PALETTE_LEN: palette_len  <= cfg_data;
        twc_pkg::REG_PERIOD_LEN:  period_len   <= cfg_data;
        twc_pkg::REG_OVER_COUNT:  over_count   <= cfg_data;
        twc_pkg::REG_ADVANCE:     advance_step <= cfg_data;
        twc_pkg::REG_RIB:         rib_fraction <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // lengths saturate at the table depths
  logic [8:0] wl_cap, fl_cap, pl_cap;
  assign wl_cap = (32'(warp_len) > twc_pkg::THREAD_DEPTH) ?
                  9'(twc_pkg::THREAD_DEPTH) : warp_len;
  assign fl_cap = (32'(weft_len) > twc_pkg::THREAD_DEPTH) ?
                  9'(twc_pkg::THREAD_DEPTH) : weft_len;
  assign pl_cap = (32'(palette_len) > twc_pkg::PALETTE_DEPTH) ?
                  9'(twc_pkg::PALETTE_DEPTH) : palette_len;

  // ---- stage 1: capture ----
  logic          vld1;
  twc_pkg::cmd_t item1;

  always_ff @(posedge clk) begin
    if (rst) vld1 <= 1'b0;
    else     vld1 <= start && !busy;
    item1 <= cmd;
  end

  // ---- stage 2: advance * pick ----
  logic                             vld2;
  twc_pkg::cmd_t                    item2;
  logic signed [twc_pkg::PROD_W-1:0] prod2;

  always_ff @(posedge clk) begin
    if (rst) vld2 <= 1'b0;
    else     vld2 <= vld1;
    item2 <= item1;
    prod2 <= twc_pkg::PROD_W'(advance_step) * twc_pkg::PROD_W'(item1.pick_coord);
  end

  // ---- stage 3: difference and magnitudes for the remainder units ----
  logic signed [twc_pkg::DIFF_W-1:0] diff;
  logic [twc_pkg::DIFF_W-1:0]        mag_d;
  logic [twc_pkg::COORD_BITS-1:0]    mag_e, mag_p;

  assign diff  = twc_pkg::DIFF_W'(item2.end_coord) - twc_pkg::DIFF_W'(prod2);
  assign mag_d = diff[twc_pkg::DIFF_W-1] ? (~diff + 1'b1) : diff;
  assign mag_e = item2.end_coord[twc_pkg::COORD_BITS-1] ?
                 (~item2.end_coord + 1'b1) : item2.end_coord;
  assign mag_p = item2.pick_coord[twc_pkg::COORD_BITS-1] ?
                 (~item2.pick_coord + 1'b1) : item2.pick_coord;

  logic                         vld3;
  side_t                        side3;
  logic [twc_pkg::DIV_BITS-1:0] div_d, div_e, div_p;

  always_ff @(posedge clk) begin
    if (rst) vld3 <= 1'b0;
    else     vld3 <= vld2;
    side3.op    <= item2.opcode;
    side3.idx   <= item2.entry_index;
    side3.shade <= item2.shade_value;
    side3.rgba  <= {item2.load_red, item2.load_green, item2.load_blue, item2.load_alpha};
    side3.neg_d <= diff[twc_pkg::DIFF_W-1];
    side3.neg_e <= item2.end_coord[twc_pkg::COORD_BITS-1];
    side3.neg_p <= item2.pick_coord[twc_pkg::COORD_BITS-1];
    div_d <= twc_pkg::DIV_BITS'(mag_d);
    div_e <= twc_pkg::DIV_BITS'(mag_e);
    div_p <= twc_pkg::DIV_BITS'(mag_p);
  end

  // ---- remainder pipelines ----
  logic [twc_pkg::REM_W-1:0] rem_d, rem_e, rem_p;

  twc_rem u_rem_twill (.clk, .dividend(div_d), .divisor(period_len), .remainder(rem_d));
  twc_rem u_rem_end   (.clk, .dividend(div_e), .divisor(wl_cap),     .remainder(rem_e));
  twc_rem u_rem_pick  (.clk, .dividend(div_p), .divisor(fl_cap),     .remainder(rem_p));

  logic  vld_q  [twc_pkg::REM_STAGES];
  side_t side_q [twc_pkg::REM_STAGES];

  always_ff @(posedge clk) begin
    if (rst) vld_q[0] <= 1'b0;
    else     vld_q[0] <= vld3;
    side_q[0] <= side3;
    for (int s = 1; s < twc_pkg::REM_STAGES; s++) begin
      if (rst) vld_q[s] <= 1'b0;
      else     vld_q[s] <= vld_q[s-1];
      side_q[s] <= side_q[s-1];
    end
  end

  // ---- fix-up stage: wrap negatives, twill rule, table addresses ----
  side_t                     side_r;
  logic [twc_pkg::REM_W-1:0] wr_d, wr_e, wr_p;
  logic                      up_c;

  assign side_r = side_q[twc_pkg::REM_STAGES-1];
  assign wr_d = (side_r.neg_d && rem_d != '0) ? period_len - rem_d : rem_d;
  assign wr_e = (side_r.neg_e && rem_e != '0) ? wl_cap - rem_e : rem_e;
  assign wr_p = (side_r.neg_p && rem_p != '0) ? fl_cap - rem_p : rem_p;

  always_comb begin
    if (over_count >= period_len)  up_c = 1'b1;
    else if (over_count == '0)     up_c = 1'b0;
    else                           up_c = wr_d < over_count;
  end

  logic                         vldf, upf, emptyf;
  side_t                        sidef;
  logic [twc_pkg::THREAD_AW-1:0] warp_addr, weft_addr;

  always_ff @(posedge clk) begin
    if (rst) vldf <= 1'b0;
    else     vldf <= vld_q[twc_pkg::REM_STAGES-1];
    sidef     <= side_r;
    upf       <= up_c;
    emptyf    <= (wl_cap == '0) || (fl_cap == '0);
    warp_addr <= twc_pkg::THREAD_AW'(wr_e);
    weft_addr <= twc_pkg::THREAD_AW'(wr_p);
  end

  // ---- shade tables ----
  logic [7:0] warp_q, weft_q;
  logic       thr_idx_ok;

  assign thr_idx_ok = 32'(sidef.idx) < twc_pkg::THREAD_DEPTH;

  twc_ram #(.WIDTH(8), .DEPTH(twc_pkg::THREAD_DEPTH)) u_warp_ram (
    .clk,
    .we   (vldf && sidef.op == twc_pkg::OP_LOAD_WARP && thr_idx_ok),
    .waddr(twc_pkg::THREAD_AW'(sidef.idx)),
    .wdata(sidef.shade),
    .raddr(warp_addr),
    .rdata(warp_q)
  );

  twc_ram #(.WIDTH(8), .DEPTH(twc_pkg::THREAD_DEPTH)) u_weft_ram (
    .clk,
    .we   (vldf && sidef.op == twc_pkg::OP_LOAD_WEFT && thr_idx_ok),
    .waddr(twc_pkg::THREAD_AW'(sidef.idx)),
    .wdata(sidef.shade),
    .raddr(weft_addr),
    .rdata(weft_q)
  );

  logic  vlds, ups, emptys;
  side_t sides;

  always_ff @(posedge clk) begin
    if (rst) vlds <= 1'b0;
    else     vlds <= vldf;
    sides  <= sidef;
    ups    <= upf;
    emptys <= emptyf;
  end

  // ---- palette ----
  logic [7:0]  shade_s;
  logic [31:0] pal_q;

  assign shade_s = ups ? warp_q : weft_q;

  twc_ram #(.WIDTH(32), .DEPTH(twc_pkg::PALETTE_DEPTH)) u_pal_ram (
    .clk,
    .we   (vlds && sides.op == twc_pkg::OP_LOAD_PAL &&
           32'(sides.idx) < twc_pkg::PALETTE_DEPTH),
    .waddr(twc_pkg::PAL_AW'(sides.idx)),
    .wdata(sides.rgba),
    .raddr(twc_pkg::PAL_AW'(shade_s)),
    .rdata(pal_q)
  );

  logic vldp, upp, emptyp, beyondp;

  always_ff @(posedge clk) begin
    if (rst) vldp <= 1'b0;
    else     vldp <= vlds && sides.op == twc_pkg::OP_SAMPLE;
    upp     <= ups;
    emptyp  <= emptys;
    beyondp <= {1'b0, shade_s} >= pl_cap;
  end

  // ---- rib darkening: c * (256 - rib), rounded in the output stage ----
  logic [8:0]  scale;
  logic        vldm, upm, emptym, beyondm;
  logic [31:0] rawm;
  logic [16:0] mr, mg, mb;

  assign scale = 9'd256 - {1'b0, rib_fraction};

  always_ff @(posedge clk) begin
    if (rst) vldm <= 1'b0;
    else     vldm <= vldp;
    upm     <= upp;
    emptym  <= emptyp;
    beyondm <= beyondp;
    rawm    <= pal_q;
    mr      <= 17'(pal_q[31:24]) * 17'(scale);
    mg      <= 17'(pal_q[23:16]) * 17'(scale);
    mb      <= 17'(pal_q[15:8])  * 17'(scale);
  end

  // ---- output register ----
  logic [16:0] rr, rg, rb;

  assign rr = mr + 17'd128;
  assign rg = mg + 17'd128;
  assign rb = mb + 17'd128;

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vldm;
    if (emptym || beyondm) begin
      result.pixel_red   <= '0;
      result.pixel_green <= '0;
      result.pixel_blue  <= '0;
      result.pixel_alpha <= '0;
    end else begin
      result.pixel_red   <= upm ? rawm[31:24] : rr[15:8];
      result.pixel_green <= upm ? rawm[23:16] : rg[15:8];
      result.pixel_blue  <= upm ? rawm[15:8]  : rb[15:8];
      result.pixel_alpha <= rawm[7:0];
    end
    result.warp_over <= upm && !emptym;
  end

  // ---- checks ----
  a_sample_gives_result: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.opcode == twc_pkg::OP_SAMPLE) |-> ##LAT done)
    else $error("sample transaction produced no result");

  a_load_gives_none: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && cmd.opcode != twc_pkg::OP_SAMPLE) |-> ##LAT !done)
    else $error("load transaction produced a result");

  a_empty_is_black: assert property (@(posedge clk) disable iff (rst)
    (vldm && emptym) |=> (done && result == '0))
    else $error("empty thread table did not give transparent black");

endmodule

[bench/twill_cloth_pixel_shader_test.sv]
module twill_cloth_pixel_shader_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 24;
  localparam int PHASES        = 10;
  localparam int PHASE_ITEMS   = 130;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              start = 1'b0;
  logic              busy;
  twc_pkg::cmd_t     cmd = '0;
  logic              done;
  twc_pkg::result_t  result;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [2:0]        cfg_index = '0;
  logic [8:0]        cfg_data = '0;

  twill_cloth_pixel_shader i_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // One command plus, for samples, the pixel it must produce.
  typedef struct {
    twc_pkg::cmd_t    c;
    bit               gives_pixel;
    twc_pkg::result_t pixel;
  } shader_op_t;

  shader_op_t       pending_ops[$];
  twc_pkg::result_t pixels_due[$];
  int               fail_count = 0;
  int               samples_checked = 0;

  // Shadow of the block: tables, written flags and register file.
  logic [7:0]  warp_tab [twc_pkg::THREAD_DEPTH];
  logic [7:0]  weft_tab [twc_pkg::THREAD_DEPTH];
  logic [31:0] pal_tab [twc_pkg::PALETTE_DEPTH];
  bit          warp_set [twc_pkg::THREAD_DEPTH];
  bit          weft_set [twc_pkg::THREAD_DEPTH];
  bit          pal_set [twc_pkg::PALETTE_DEPTH];
  logic [8:0]  warp_len = 9'd0, weft_len = 9'd0, palette_len = 9'd0;
  logic [8:0]  period_len = 9'd4, over_count = 9'd2, advance_step = 9'd1;
  logic [7:0]  rib_fraction = 8'd0;

  function automatic longint wrap_mod(longint v, longint n);
    longint r;
    r = v % n;
    if (r < 0) r += n;
    return r;
  endfunction

  function automatic longint capped(logic [8:0] v, int lim);
    return (longint'(v) > longint'(lim)) ? longint'(lim) : longint'(v);
  endfunction

  function automatic logic [7:0] shade_darken(logic [7:0] c);
    int unsigned v;
    v = (32'(c) * (32'd256 - 32'(rib_fraction)) + 32'd128) >> 8;
    return v[7:0];
  endfunction

  function automatic bit warp_shows(longint e, longint p);
    longint adv;
    if (over_count >= period_len) return 1'b1;
    if (over_count == 0) return 1'b0;
    adv = longint'($signed(advance_step));
    return wrap_mod(e - adv * p, longint'(period_len)) < longint'(over_count);
  endfunction

  task automatic queue_load(twc_pkg::opcode_t op, logic [7:0] idx, logic [7:0] shade);
    shader_op_t o;
    o.c = '0;
    o.c.end_coord = 16'($urandom);
    o.c.pick_coord = 16'($urandom);
    o.c.load_red = 8'($urandom);
    o.c.load_green = 8'($urandom);
    o.c.load_blue = 8'($urandom);
    o.c.load_alpha = 8'($urandom);
    o.c.opcode = op;
    o.c.entry_index = idx;
    o.c.shade_value = shade;
    o.gives_pixel = 1'b0;
    o.pixel = '0;
    case (op)
      twc_pkg::OP_LOAD_WARP: begin warp_tab[idx] = shade; warp_set[idx] = 1'b1; end
      twc_pkg::OP_LOAD_WEFT: begin weft_tab[idx] = shade; weft_set[idx] = 1'b1; end
      twc_pkg::OP_LOAD_PAL: begin
        pal_tab[idx] = {o.c.load_red, o.c.load_green, o.c.load_blue, o.c.load_alpha};
        pal_set[idx] = 1'b1;
      end
      default: ;
    endcase
    pending_ops = {pending_ops, o};
  endtask

  // Shade for a table fill: mostly inside the palette so colours get exercised.
  function automatic logic [7:0] pick_shade();
    longint pl;
    pl = capped(palette_len, twc_pkg::PALETTE_DEPTH);
    if (pl > 0 && $urandom_range(0, 9) < 8) return 8'($urandom_range(0, 32'(pl - 1)));
    return 8'($urandom);
  endfunction

  // Queues a sample, first filling any table entry it would read unwritten.
  task automatic queue_sample(logic signed [15:0] e, logic signed [15:0] p);
    shader_op_t o;
    longint wl, fl, pl, idx;
    logic [7:0] shade;
    logic [31:0] rgba;
    bit up;
    o.c = '0;
    o.c.entry_index = 8'($urandom);
    o.c.load_red = 8'($urandom);
    o.c.load_green = 8'($urandom);
    o.c.load_blue = 8'($urandom);
    o.c.load_alpha = 8'($urandom);
    o.c.opcode = twc_pkg::OP_SAMPLE;
    o.c.end_coord = e;
    o.c.pick_coord = p;
    o.c.shade_value = 8'($urandom);
    o.gives_pixel = 1'b1;
    o.pixel = '0;
    wl = capped(warp_len, twc_pkg::THREAD_DEPTH);
    fl = capped(weft_len, twc_pkg::THREAD_DEPTH);
    pl = capped(palette_len, twc_pkg::PALETTE_DEPTH);
    if (wl != 0 && fl != 0) begin
      up = warp_shows(longint'(e), longint'(p));
      if (up) begin
        idx = wrap_mod(longint'(e), wl);
        if (!warp_set[idx]) queue_load(twc_pkg::OP_LOAD_WARP, 8'(idx), pick_shade());
        shade = warp_tab[idx];
      end else begin
        idx = wrap_mod(longint'(p), fl);
        if (!weft_set[idx]) queue_load(twc_pkg::OP_LOAD_WEFT, 8'(idx), pick_shade());
        shade = weft_tab[idx];
      end
      o.pixel.warp_over = up;
      if (shade < pl) begin
        if (!pal_set[shade]) queue_load(twc_pkg::OP_LOAD_PAL, shade, 8'($urandom));
        rgba = pal_tab[shade];
        o.pixel.pixel_red   = up ? rgba[31:24] : shade_darken(rgba[31:24]);
        o.pixel.pixel_green = up ? rgba[23:16] : shade_darken(rgba[23:16]);
        o.pixel.pixel_blue  = up ? rgba[15:8]  : shade_darken(rgba[15:8]);
        o.pixel.pixel_alpha = rgba[7:0];
      end
    end
    pending_ops = {pending_ops, o};
  endtask

  // Driver: one command transaction at a time, random gaps with calm stretches.
  shader_op_t in_flight;
  int         gap_left = 0;
  bit         steady = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy && in_flight.gives_pixel) pixels_due = {pixels_due, in_flight.pixel};
      if (!start || !busy) begin
        if (gap_left > 0) begin
          gap_left--;
          start <= 1'b0;
        end else if (pending_ops.size() > 0) begin
          in_flight = pending_ops.pop_front();
          cmd <= in_flight.c;
          start <= 1'b1;
          if ($urandom_range(0, 31) == 0) steady = !steady;
          gap_left = steady ? 0 : $urandom_range(0, 16);
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every done strobe is matched against the oldest pixel due.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (pixels_due.size() == 0) begin
        $error("pixel result with none outstanding");
        fail_count++;
      end else begin
        twc_pkg::result_t want;
        want = pixels_due.pop_front();
        samples_checked++;
        if (result.pixel_red !== want.pixel_red) begin
          $error("pixel_red: expected %0d, got %0d", want.pixel_red, result.pixel_red);
          fail_count++;
        end
        if (result.pixel_green !== want.pixel_green) begin
          $error("pixel_green: expected %0d, got %0d", want.pixel_green, result.pixel_green);
          fail_count++;
        end
        if (result.pixel_blue !== want.pixel_blue) begin
          $error("pixel_blue: expected %0d, got %0d", want.pixel_blue, result.pixel_blue);
          fail_count++;
        end
        if (result.pixel_alpha !== want.pixel_alpha) begin
          $error("pixel_alpha: expected %0d, got %0d", want.pixel_alpha, result.pixel_alpha);
          fail_count++;
        end
        if (result.warp_over !== want.warp_over) begin
          $error("warp_over: expected %0d, got %0d", want.warp_over, result.warp_over);
          fail_count++;
        end
      end
    end
  end

  // Wait for the command queue and every outstanding pixel, then let loads settle.
  task automatic drain();
    do @(posedge clk);
    while (pending_ops.size() != 0 || start || pixels_due.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(twc_pkg::reg_index_t r, logic [8:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    @(posedge clk);
    case (r)
      twc_pkg::REG_WARP_LEN:    warp_len = v;
      twc_pkg::REG_WEFT_LEN:    weft_len = v;
      twc_pkg::REG_PALETTE_LEN: palette_len = v;
      twc_pkg::REG_PERIOD_LEN:  period_len = v;
      twc_pkg::REG_OVER_COUNT:  over_count = v;
      twc_pkg::REG_ADVANCE:     advance_step = v;
      twc_pkg::REG_RIB:         rib_fraction = v[7:0];
      default: ;
    endcase
  endtask

  function automatic logic [8:0] pick_len();
    case ($urandom_range(0, 6))
      0: return 9'd1;
      1: return 9'd256;
      2: return 9'($urandom_range(257, 511));
      default: return 9'($urandom_range(1, 256));
    endcase
  endfunction

  function automatic logic signed [15:0] pick_coord();
    case ($urandom_range(0, 9))
      0: return 16'sh8000;
      1: return 16'sh7fff;
      2: return 16'($urandom_range(0, 15) - 8);
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [8:0] per;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: reset registers give empty tables, hence transparent output.
    queue_sample(16'sh0000, 16'sh0000);
    drain();
    write_reg(twc_pkg::REG_WARP_LEN, 9'd4);
    write_reg(twc_pkg::REG_WEFT_LEN, 9'd4);
    write_reg(twc_pkg::REG_PALETTE_LEN, 9'd8);
    queue_load(twc_pkg::OP_LOAD_PAL, 8'd0, 8'd0);
    pending_ops[$].c.load_red = 8'hff;
    pending_ops[$].c.load_green = 8'hff;
    pending_ops[$].c.load_blue = 8'hff;
    pending_ops[$].c.load_alpha = 8'hff;
    pal_tab[0] = 32'hffffffff;
    queue_load(twc_pkg::OP_LOAD_PAL, 8'd255, 8'd0);
    queue_load(twc_pkg::OP_LOAD_WARP, 8'd0, 8'd255);   // shade outside the palette
    queue_load(twc_pkg::OP_LOAD_WEFT, 8'd0, 8'd0);
    queue_sample(16'sh0000, 16'sh0000);
    queue_sample(16'sh8000, 16'sh7fff);
    queue_sample(16'sh7fff, 16'sh8000);
    queue_sample(16'shffff, 16'shffff);
    queue_sample(16'sh0003, 16'sh0001);
    drain();
    write_reg(twc_pkg::REG_RIB, 9'd255);             // darkest rib on weft pixels
    write_reg(twc_pkg::REG_PERIOD_LEN, 9'd0);        // zero period: warp always up
    queue_sample(16'sh0001, 16'sh0002);
    drain();
    write_reg(twc_pkg::REG_PERIOD_LEN, 9'd4);
    write_reg(twc_pkg::REG_OVER_COUNT, 9'd0);        // no overs: weft always shows
    write_reg(twc_pkg::REG_ADVANCE, 9'h100);
    queue_sample(16'sh0002, 16'sh8000);
    queue_sample(16'sh7fff, 16'sh0001);
    drain();

    // Random phases, each under a fresh register setting, extremes included.
    for (int ph = 0; ph < PHASES; ph++) begin
      per = (ph == 0) ? 9'd511 : (ph == 1) ? 9'd1 : (ph == 2) ? 9'd0 : pick_len();
      write_reg(twc_pkg::REG_WARP_LEN, (ph == 3) ? 9'd0 : (ph == 0) ? 9'd511 : pick_len());
      write_reg(twc_pkg::REG_WEFT_LEN, (ph == 4) ? 9'd0 : (ph == 0) ? 9'd511 : pick_len());
      write_reg(twc_pkg::REG_PALETTE_LEN,
                (ph == 5) ? 9'd0 : (ph == 0) ? 9'd511 : pick_len());
      write_reg(twc_pkg::REG_PERIOD_LEN, per);
      write_reg(twc_pkg::REG_OVER_COUNT, (ph == 0) ? 9'd511 : (ph == 6) ? per :
                9'($urandom_range(0, 32'(per) + 1)));
      write_reg(twc_pkg::REG_ADVANCE,
                (ph == 0) ? 9'h0ff : (ph == 1) ? 9'h101 : 9'($urandom));
      write_reg(twc_pkg::REG_RIB,
                (ph == 0) ? 9'd255 : (ph == 1) ? 9'd0 : 9'($urandom_range(0, 255)));
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(0, 9) < 6) queue_sample(pick_coord(), pick_coord());
        else case ($urandom_range(0, 2))
          0: queue_load(twc_pkg::OP_LOAD_WARP, 8'($urandom), pick_shade());
          1: queue_load(twc_pkg::OP_LOAD_WEFT, 8'($urandom), pick_shade());
          default: queue_load(twc_pkg::OP_LOAD_PAL, 8'($urandom), 8'd0);
        endcase
      end
      drain();
    end

    $display("Checked %0d pixels over %0d register settings, with table loads,",
             samples_checked, PHASES + 4);
    $display("empty tables, zero period and shades outside the palette.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("FAILURE");
    $finish;
  end

endmodule

[sim.f]
sv/twc_pkg.sv
sv/twc_ram.sv
sv/twc_rem.sv
sv/twill_cloth_pixel_shader.sv
bench/twill_cloth_pixel_shader_test.sv
